// ----- sv/icy_metadata_demux_macros.svh -----
// Assertion macros shared by the checker of the ICY metadata demultiplexer.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef ICY_METADATA_DEMUX_MACROS_SVH
`define ICY_METADATA_DEMUX_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ICYMD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ICYMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/icymd_pkg.sv -----
// Shared types and constants of the ICY metadata demultiplexer.
// No dependencies; imported by every module of the block.
package icymd_pkg;

  // Widths of the stream and configuration fields
  localparam int unsigned ByteW     = 8;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned MetaLenW  = 12;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // Metadata length unit is 16 bytes: length byte shifted left by four
  localparam int unsigned MetaUnitShift = 4;

  // Reset value of the metadata length limit
  localparam logic [MetaLenW-1:0] MaxMetaReset = MetaLenW'(512);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDemuxEnable  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMetaInterval = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxMetaBytes = 2'd2;

  // Byte kind codes
  localparam logic KindAudio = 1'b0;
  localparam logic KindMeta  = 1'b1;

  // Result of one accepted byte, from the control unit to the output stage
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
    logic             kind;
    logic             last;
    logic             rejected;
  } icymd_res_t;

endpackage

// ----- sv/icymd_ctrl.sv -----
// Configuration registers and interval/metadata counters of the ICY demultiplexer.
// Classifies each accepted byte in one pass; depends on icymd_pkg.
module icymd_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [icymd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [icymd_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                             step_i,
  input  logic [icymd_pkg::ByteW-1:0]      in_byte_i,
  output icymd_pkg::icymd_res_t            res_o
);
  import icymd_pkg::*;

  logic                 enable_q, enable_d;
  logic [IntervalW-1:0] interval_q, interval_d;
  logic [MetaLenW-1:0]  max_meta_q, max_meta_d;
  logic                 in_meta_q, in_meta_d;
  logic [IntervalW-1:0] audio_left_q, audio_left_d;
  logic [MetaLenW-1:0]  meta_left_q, meta_left_d;

  logic [MetaLenW-1:0]  meta_len;
  logic [MetaLenW-1:0]  meta_dec;
  logic                 restart;

  // Length byte times 16 always fits the 12-bit length
  assign meta_len = {in_byte_i, {MetaUnitShift{1'b0}}};
  assign meta_dec = meta_left_q - MetaLenW'(1);

  // Decode configuration writes
  always_comb begin
    enable_d   = enable_q;
    interval_d = interval_q;
    max_meta_d = max_meta_q;
    restart    = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDemuxEnable: begin
          enable_d = cfg_wdata_i[0];
          restart  = 1'b1;
        end
        RegMetaInterval: begin
          interval_d = cfg_wdata_i;
          restart    = 1'b1;
        end
        RegMaxMetaBytes: begin
          max_meta_d = cfg_wdata_i[MetaLenW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Classify the byte and advance the counters
  always_comb begin
    in_meta_d      = in_meta_q;
    audio_left_d   = audio_left_q;
    meta_left_d    = meta_left_q;
    res_o.valid    = 1'b0;
    res_o.data     = in_byte_i;
    res_o.kind     = KindAudio;
    res_o.last     = 1'b0;
    res_o.rejected = 1'b0;

    if (!enable_q) begin
      // Passthrough: hold the counters
      res_o.valid = 1'b1;
    end else if (in_meta_q) begin
      meta_left_d = meta_dec;
      res_o.valid = 1'b1;
      res_o.kind  = KindMeta;
      if (meta_dec == '0) begin
        res_o.last   = 1'b1;
        in_meta_d    = 1'b0;
        audio_left_d = interval_q;
      end
    end else if (audio_left_q != '0) begin
      audio_left_d = audio_left_q - IntervalW'(1);
      res_o.valid  = 1'b1;
    end else if (meta_len == '0) begin
      // Empty metadata block: drop the length byte, start a new interval
      audio_left_d = interval_q;
    end else if (meta_len > max_meta_q) begin
      // Oversize length: pass it on as the first audio byte of an interval
      audio_left_d   = (interval_q == '0) ? '0 : interval_q - IntervalW'(1);
      res_o.valid    = 1'b1;
      res_o.rejected = 1'b1;
    end else begin
      in_meta_d   = 1'b1;
      meta_left_d = meta_len;
    end

    // Drop any result when no byte is taken
    if (!step_i) begin
      in_meta_d    = in_meta_q;
      audio_left_d = audio_left_q;
      meta_left_d  = meta_left_q;
      res_o.valid  = 1'b0;
    end

    // Restart counting after an enable or interval write
    if (restart) begin
      in_meta_d    = 1'b0;
      audio_left_d = interval_d;
      meta_left_d  = '0;
    end
  end

  // Hold configuration and counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      interval_q   <= '0;
      max_meta_q   <= MaxMetaReset;
      in_meta_q    <= 1'b0;
      audio_left_q <= '0;
      meta_left_q  <= '0;
    end else begin
      enable_q     <= enable_d;
      interval_q   <= interval_d;
      max_meta_q   <= max_meta_d;
      in_meta_q    <= in_meta_d;
      audio_left_q <= audio_left_d;
      meta_left_q  <= meta_left_d;
    end
  end

endmodule

// ----- sv/icy_metadata_demux.sv -----
// ICY metadata demultiplexer: takes one stream byte per cycle while in_ready_o
// is high and tags it as audio or metadata. Each accepted byte is classified in the
// same cycle and its result (if any) is held in a single output register, which
// frees again in the cycle it is taken, so the block sustains one byte per clock
// while downstream is ready; throughput is set by that register and out_ready_i.
// Length bytes of zero and accepted length bytes produce no output transaction.
// There is no clearing pass after reset. Depends on icymd_pkg and icymd_ctrl.
module icy_metadata_demux (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [icymd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [icymd_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [icymd_pkg::ByteW-1:0]       in_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [icymd_pkg::ByteW-1:0]       out_byte_o,
  output logic                              byte_kind_o,
  output logic                              meta_last_o,
  output logic                              length_rejected_o
);
  import icymd_pkg::*;

  icymd_res_t       res;
  logic             accept;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q;
  logic             kind_q, last_q, rejected_q;

  // Take a transaction whenever the output register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  icymd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (accept),
    .in_byte_i   (in_byte_i),
    .res_o       (res)
  );

  // Output valid: load on accept, clear once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = res.valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload: capture only when a result is produced
  always_ff @(posedge clk_i) begin
    if (accept && res.valid) begin
      out_byte_q <= res.data;
      kind_q     <= res.kind;
      last_q     <= res.last;
      rejected_q <= res.rejected;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_byte_o        = out_byte_q;
  assign byte_kind_o       = kind_q;
  assign meta_last_o       = last_q;
  assign length_rejected_o = rejected_q;

endmodule

// ----- sv/icymd_checker.sv -----
// Port-level checker for the ICY metadata demultiplexer, bound to the top level.
// Depends on icymd_pkg and icy_metadata_demux_macros.svh.
`include "icy_metadata_demux_macros.svh"

module icymd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [icymd_pkg::ByteW-1:0]    out_byte_o,
  input logic                           byte_kind_o,
  input logic                           meta_last_o,
  input logic                           length_rejected_o
);
  import icymd_pkg::*;

  // A stalled result holds with its payload
  `ICYMD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_byte_o) && $stable(byte_kind_o) && $stable(meta_last_o), "stalled result changed")

  // The input side is ready exactly when the output register can take a result
  `ICYMD_ASSERT_NOW(a_ready_map, 1'b1, in_ready_o == (!out_valid_o || out_ready_i), "input ready does not follow output register state")

  // End of block is only flagged on metadata bytes
  `ICYMD_ASSERT_NOW(a_last_meta, out_valid_o && meta_last_o, byte_kind_o == KindMeta, "meta_last on an audio byte")

  // A rejected length goes out as a plain audio byte
  `ICYMD_ASSERT_NOW(a_rej_audio, out_valid_o && length_rejected_o, byte_kind_o == KindAudio && !meta_last_o, "rejected length not tagged as audio")

endmodule

bind icy_metadata_demux icymd_checker u_icymd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .out_byte_o        (out_byte_o),
  .byte_kind_o       (byte_kind_o),
  .meta_last_o       (meta_last_o),
  .length_rejected_o (length_rejected_o)
);
